>>> rtl/cfp_pkg.sv
// Shared constants, types and helpers of the command frame parser.
package cfp_pkg;

  localparam int unsigned ID_DIGITS = 3;
  localparam int unsigned ACC_W     = $clog2(10 ** ID_DIGITS);
  localparam int unsigned CNT_W     = $clog2(ID_DIGITS + 1);
  localparam int unsigned ID_W      = 10;
  localparam int unsigned CMP_W     = ACC_W + 8;
  localparam int unsigned ID_MAX    = (1 << ID_W) - 1;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [7:0] FID_WRITE   = 8'd0;
  localparam logic [7:0] FID_READ    = 8'd128;
  localparam logic [7:0] FID_TEDS    = 8'd160;
  localparam logic [7:0] FID_ID_TEDS = 8'd161;

  typedef enum logic [2:0] {
    CLS_WRITE   = 3'd0,
    CLS_READ    = 3'd1,
    CLS_TEDS    = 3'd2,
    CLS_ID_TEDS = 3'd3,
    CLS_UNSUP   = 3'd4
  } cmd_class_e;

  function automatic logic [ID_W-1:0] sat_id(input logic [ACC_W-1:0] v);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(v);
    if (wide > CMP_W'(ID_MAX)) begin
      return '1;
    end
    return ID_W'(v);
  endfunction

  function automatic logic fid_is(input logic [ACC_W-1:0] v, input logic [7:0] code);
    return CMP_W'(v) == CMP_W'(code);
  endfunction

endpackage

>>> rtl/command_frame_parser.sv
// Character-driven command frame parser: input register, parse state, result register.
// Order: a closing carriage return is first captured in the input register, and its result
// is then written to the result register once the output is free.
// Throughput: one character per cycle; a held result stalls input only at the next
// closing carriage return, the other characters keep flowing past it.
// Reset: asynchronous, active low; clears the frame state and both valid flags.
module command_frame_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_char_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cfp_pkg::ID_W-1:0]  function_id_o,
  output logic [cfp_pkg::ID_W-1:0]  channel_id_o,
  output logic                      is_global_o,
  output logic [2:0]                command_class_o,
  output logic                      frame_status_o
);

  logic                        s1_valid_q;
  logic [7:0]                  s1_char_q;
  logic                        s1_load, s1_adv, step;

  logic                        in_frame_q, in_frame_d;
  logic                        in_chan_q, in_chan_d;
  logic [cfp_pkg::ACC_W-1:0]   func_acc_q, func_acc_d;
  logic [cfp_pkg::ACC_W-1:0]   chan_acc_q, chan_acc_d;
  logic [cfp_pkg::CNT_W-1:0]   func_cnt_q, func_cnt_d;
  logic [cfp_pkg::CNT_W-1:0]   chan_cnt_q, chan_cnt_d;
  logic                        bad_q, bad_d;

  logic                        out_valid_q, out_valid_d, out_free, emit;
  logic [cfp_pkg::ID_W-1:0]    func_out_q, chan_out_q;
  logic                        global_q, status_q;
  cfp_pkg::cmd_class_e         class_q, class_d;
  logic                        bad_end, is_digit, is_dollar, is_cr, is_comma;
  logic [cfp_pkg::ACC_W-1:0]   acc_sel, acc_next;
  logic [cfp_pkg::CNT_W-1:0]   cnt_sel;
  logic                        cnt_full;

  assign is_dollar = s1_char_q == cfp_pkg::CHAR_DOLLAR;
  assign is_cr     = s1_char_q == cfp_pkg::CHAR_CR;
  assign is_comma  = s1_char_q == cfp_pkg::CHAR_COMMA;
  assign is_digit  = (s1_char_q >= cfp_pkg::CHAR_ZERO) && (s1_char_q <= cfp_pkg::CHAR_NINE);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = s1_valid_q && in_frame_q && !is_dollar && is_cr;
  assign s1_adv     = !emit || out_free;
  assign step       = s1_valid_q && s1_adv;
  assign s1_load    = !s1_valid_q || s1_adv;
  assign in_stall_o = !s1_load;

  // hold the incoming character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_char_q <= rx_char_i;
    end
  end

  assign acc_sel  = in_chan_q ? chan_acc_q : func_acc_q;
  assign cnt_sel  = in_chan_q ? chan_cnt_q : func_cnt_q;
  assign cnt_full = cnt_sel >= cfp_pkg::CNT_W'(cfp_pkg::ID_DIGITS);
  assign acc_next = cfp_pkg::ACC_W'({acc_sel, 3'b000}) + cfp_pkg::ACC_W'({acc_sel, 1'b0})
                  + cfp_pkg::ACC_W'(s1_char_q[3:0]);

  assign bad_end = bad_q || !in_chan_q || (func_cnt_q == '0) || (chan_cnt_q == '0);

  always_comb begin
    priority if (bad_end) begin
      class_d = cfp_pkg::CLS_UNSUP;
    end else if (cfp_pkg::fid_is(func_acc_q, cfp_pkg::FID_WRITE)) begin
      class_d = cfp_pkg::CLS_WRITE;
    end else if (cfp_pkg::fid_is(func_acc_q, cfp_pkg::FID_READ)) begin
      class_d = cfp_pkg::CLS_READ;
    end else if (cfp_pkg::fid_is(func_acc_q, cfp_pkg::FID_TEDS)) begin
      class_d = cfp_pkg::CLS_TEDS;
    end else if (cfp_pkg::fid_is(func_acc_q, cfp_pkg::FID_ID_TEDS)) begin
      class_d = cfp_pkg::CLS_ID_TEDS;
    end else begin
      class_d = cfp_pkg::CLS_UNSUP;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    in_chan_d  = in_chan_q;
    func_acc_d = func_acc_q;
    chan_acc_d = chan_acc_q;
    func_cnt_d = func_cnt_q;
    chan_cnt_d = chan_cnt_q;
    bad_d      = bad_q;
    if (is_dollar || (in_frame_q && is_cr)) begin
      in_frame_d = is_dollar;
      in_chan_d  = 1'b0;
      func_acc_d = '0;
      chan_acc_d = '0;
      func_cnt_d = '0;
      chan_cnt_d = '0;
      bad_d      = 1'b0;
    end else if (in_frame_q) begin
      priority if (is_digit) begin
        if (cnt_full) begin
          bad_d = 1'b1;
        end else if (in_chan_q) begin
          chan_acc_d = acc_next;
          chan_cnt_d = chan_cnt_q + 1'b1;
        end else begin
          func_acc_d = acc_next;
          func_cnt_d = func_cnt_q + 1'b1;
        end
      end else if (is_comma) begin
        if (in_chan_q) begin
          bad_d = 1'b1;
        end else begin
          in_chan_d = 1'b1;
        end
      end else begin
        bad_d = 1'b1;
      end
    end
  end

  // advance the parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      in_chan_q  <= 1'b0;
      func_acc_q <= '0;
      chan_acc_q <= '0;
      func_cnt_q <= '0;
      chan_cnt_q <= '0;
      bad_q      <= 1'b0;
    end else if (step) begin
      in_frame_q <= in_frame_d;
      in_chan_q  <= in_chan_d;
      func_acc_q <= func_acc_d;
      chan_acc_q <= chan_acc_d;
      func_cnt_q <= func_cnt_d;
      chan_cnt_q <= chan_cnt_d;
      bad_q      <= bad_d;
    end
  end

  always_comb begin
    if (emit && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (emit && out_free) begin
      func_out_q <= cfp_pkg::sat_id(func_acc_q);
      chan_out_q <= cfp_pkg::sat_id(chan_acc_q);
      global_q   <= !bad_end && (chan_acc_q == '0);
      class_q    <= class_d;
      status_q   <= bad_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign function_id_o   = func_out_q;
  assign channel_id_o    = chan_out_q;
  assign is_global_o     = global_q;
  assign command_class_o = class_q;
  assign frame_status_o  = status_q;

endmodule

>>> rtl/cfp_checker.sv
// Port-level checker of the command frame parser and its bind.
module cfp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [7:0]                rx_char_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [cfp_pkg::ID_W-1:0]  function_id_o,
  input logic [cfp_pkg::ID_W-1:0]  channel_id_o,
  input logic                      is_global_o,
  input logic [2:0]                command_class_o,
  input logic                      frame_status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(function_id_o)
      && $stable(channel_id_o) && $stable(command_class_o) && $stable(frame_status_o))
    else $error("stalled result item changed");

  a_bad_unsup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o |->
      (command_class_o == cfp_pkg::CLS_UNSUP) && !is_global_o)
    else $error("malformed item not reported as unsupported");

  a_global: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_global_o |-> (channel_id_o == '0) && !frame_status_o)
    else $error("global flag without channel zero");

  a_read_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_class_o == cfp_pkg::CLS_READ) |->
      function_id_o == cfp_pkg::ID_W'(cfp_pkg::FID_READ))
    else $error("read class with wrong function id");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_class_o == cfp_pkg::CLS_WRITE) |->
      (function_id_o == '0) && !frame_status_o)
    else $error("write class with nonzero function id");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for the command frame parser: frame grammar, classes and handshakes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL      = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct {
    logic [cfp_pkg::ID_W-1:0] fid;
    logic [cfp_pkg::ID_W-1:0] cid;
    logic                     glob;
    cfp_pkg::cmd_class_e      cls;
    logic                     bad;
  } frame_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [7:0]                rx_char_i = 8'h00;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b1;
  logic [cfp_pkg::ID_W-1:0]  function_id_o;
  logic [cfp_pkg::ID_W-1:0]  channel_id_o;
  logic                      is_global_o;
  logic [2:0]                command_class_o;
  logic                      frame_status_o;

  frame_result_t     pending_frames[$];
  int                mismatches = 0;
  int                chars_sent = 0;
  int                quiet_cycles = 0;
  bit                idle_on = 1'b1;
  bit                hold_req = 1'b0;

  // frame parse state
  bit                frm_open;
  bit                in_chan;
  bit                frm_bad;
  int unsigned       func_val;
  int unsigned       func_cnt;
  int unsigned       chan_val;
  int unsigned       chan_cnt;

  command_frame_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_char_i       (rx_char_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .function_id_o   (function_id_o),
    .channel_id_o    (channel_id_o),
    .is_global_o     (is_global_o),
    .command_class_o (command_class_o),
    .frame_status_o  (frame_status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic clear_frame();
    in_chan  = 1'b0;
    frm_bad  = 1'b0;
    func_val = 0;
    func_cnt = 0;
    chan_val = 0;
    chan_cnt = 0;
  endtask

  task automatic parse_char(input logic [7:0] c);
    frame_result_t r;
    bit            bad;
    int unsigned   d;
    if (c == cfp_pkg::CHAR_DOLLAR) begin
      frm_open = 1'b1;
      clear_frame();
    end else if (frm_open) begin
      if (c == cfp_pkg::CHAR_CR) begin
        bad = frm_bad || !in_chan || func_cnt == 0 || chan_cnt == 0;
        r.cls = cfp_pkg::CLS_UNSUP;
        if (!bad) begin
          if (func_val == cfp_pkg::FID_WRITE) r.cls = cfp_pkg::CLS_WRITE;
          else if (func_val == cfp_pkg::FID_READ) r.cls = cfp_pkg::CLS_READ;
          else if (func_val == cfp_pkg::FID_TEDS) r.cls = cfp_pkg::CLS_TEDS;
          else if (func_val == cfp_pkg::FID_ID_TEDS) r.cls = cfp_pkg::CLS_ID_TEDS;
        end
        r.fid  = (func_val > cfp_pkg::ID_MAX) ? cfp_pkg::ID_W'(cfp_pkg::ID_MAX)
                                              : cfp_pkg::ID_W'(func_val);
        r.cid  = (chan_val > cfp_pkg::ID_MAX) ? cfp_pkg::ID_W'(cfp_pkg::ID_MAX)
                                              : cfp_pkg::ID_W'(chan_val);
        r.glob = !bad && chan_val == 0;
        r.bad  = bad;
        pending_frames.push_back(r);
        frm_open = 1'b0;
        clear_frame();
      end else if (c >= cfp_pkg::CHAR_ZERO && c <= cfp_pkg::CHAR_NINE) begin
        d = c - cfp_pkg::CHAR_ZERO;
        if (in_chan) begin
          if (chan_cnt >= cfp_pkg::ID_DIGITS) frm_bad = 1'b1;
          else begin
            chan_val = chan_val * 10 + d;
            chan_cnt++;
          end
        end else begin
          if (func_cnt >= cfp_pkg::ID_DIGITS) frm_bad = 1'b1;
          else begin
            func_val = func_val * 10 + d;
            func_cnt++;
          end
        end
      end else if (c == cfp_pkg::CHAR_COMMA) begin
        if (in_chan) frm_bad = 1'b1;
        else in_chan = 1'b1;
      end else begin
        frm_bad = 1'b1;
      end
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    for (int i = 0; i < gap; i++) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_char_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_frame(input string body);
    send_char(cfp_pkg::CHAR_DOLLAR);
    send_text(body);
    send_char(cfp_pkg::CHAR_CR);
  endtask

  task automatic send_id(input int unsigned v, input int n);
    for (int p = n - 1; p >= 0; p--) begin
      send_char(8'(cfp_pkg::CHAR_ZERO + (v / (10 ** p)) % 10));
    end
  endtask

  task automatic send_id_random(input int unsigned v);
    int least;
    least = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
    send_id(v, $urandom_range(least, cfp_pkg::ID_DIGITS));
  endtask

  task automatic send_good_frame();
    int unsigned fid;
    int unsigned cid;
    case ($urandom_range(0, 5))
      0: fid = cfp_pkg::FID_WRITE;
      1: fid = cfp_pkg::FID_READ;
      2: fid = cfp_pkg::FID_TEDS;
      3: fid = cfp_pkg::FID_ID_TEDS;
      default: fid = $urandom_range(0, 999);
    endcase
    cid = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 999);
    send_char(cfp_pkg::CHAR_DOLLAR);
    send_id_random(fid);
    send_char(cfp_pkg::CHAR_COMMA);
    send_id_random(cid);
    send_char(cfp_pkg::CHAR_CR);
  endtask

  task automatic send_broken_frame();
    int len;
    int pick;
    len = $urandom_range(1, 10);
    send_char(cfp_pkg::CHAR_DOLLAR);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) send_char(8'(cfp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      else if (pick < 13) send_char(cfp_pkg::CHAR_COMMA);
      else if (pick < 17) send_char(8'($urandom_range(0, 255)));
      else if (pick < 18) send_char(cfp_pkg::CHAR_DOLLAR);
      else send_char(cfp_pkg::CHAR_CR);
    end
    if ($urandom_range(0, 3) != 0) send_char(cfp_pkg::CHAR_CR);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_frames.size() != 0);
  endtask

  task automatic test_directed();
    send_frame("0,0");
    send_frame("128,5");
    send_frame("160,999");
    send_frame("161,1");
    send_frame("999,000");
    send_frame("1234,5");
    send_frame("1,2,3");
    send_frame("42");
    send_frame(",7");
    send_frame("7,");
    send_frame("1a,2");
    send_char(cfp_pkg::CHAR_CR);
    send_text("zz");
    send_text("$12");
    send_frame("128,0");
    send_char(cfp_pkg::CHAR_DOLLAR);
    send_char(8'h00);
    send_char(8'hFF);
    send_text("0,1");
    send_char(cfp_pkg::CHAR_CR);
    send_frame("0000,0000");
  endtask

  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_frame("0,1");
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_good_frame();
    wait_drained();
    for (int i = 0; i < 10; i++) send_good_frame();
  endtask

  task automatic test_random_frames();
    int frames;
    int pick;
    frames = 0;
    while (chars_sent < ITEM_GOAL) begin
      if (frames % 60 == 59) idle_on = ~idle_on;
      pick = $urandom_range(0, 9);
      if (pick < 7) send_good_frame();
      else if (pick < 9) send_broken_frame();
      else send_char(8'($urandom_range(0, 255)));
      frames++;
    end
    idle_on = 1'b1;
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_frames.size() == 0) begin
        note_failure($sformatf("unexpected result fid=%0d cid=%0d glob=%0d cls=%0d bad=%0d",
                               function_id_o, channel_id_o, is_global_o, command_class_o,
                               frame_status_o));
      end else begin
        want = pending_frames.pop_front();
        if (function_id_o !== want.fid || channel_id_o !== want.cid ||
            is_global_o !== want.glob || command_class_o !== 3'(want.cls) ||
            frame_status_o !== want.bad) begin
          note_failure($sformatf(
            "mismatch: expected fid=%0d cid=%0d glob=%0d cls=%0d bad=%0d, got %0d %0d %0d %0d %0d",
            want.fid, want.cid, want.glob, want.cls, want.bad, function_id_o, channel_id_o,
            is_global_o, command_class_o, frame_status_o));
        end
      end
    end
  end

  initial begin
    int n;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        for (int i = 0; i < LONG_HOLD; i++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        hold_req = 1'b0;
      end
      n = idle_on ? $urandom_range(0, 6) : 0;
      for (int i = 0; i < n; i++) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    frm_open = 1'b0;
    clear_frame();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_frames();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mismatches += pending_frames.size();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cfp_pkg.sv
rtl/command_frame_parser.sv
rtl/cfp_checker.sv
sim/testbench.sv
